// File: src/str_pkg.sv
// ----------------------------------------------------------------------------
// str_pkg
// Shared constants for the scrolling trace redraw core.
// ----------------------------------------------------------------------------
package str_pkg;

  localparam int HW = 7;  // stored height width

  localparam logic [8:0]        LEFT_ORIGIN = 9'd20;
  localparam logic [HW-1:0]     BASE_Y      = 7'd121;
  localparam logic signed [16:0] MID_HEIGHT = 17'sd50;
  localparam logic signed [16:0] MAX_HEIGHT = 17'sd100;

  typedef enum logic {
    OP_PUSH    = 1'b0,
    OP_REFRESH = 1'b1
  } op_t;

endpackage

// File: src/str_ram.sv
// ----------------------------------------------------------------------------
// str_ram
// Simple dual-port RAM, one write and one registered read port.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module str_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/scrolling_trace_redraw_core.sv
// ----------------------------------------------------------------------------
// scrolling_trace_redraw_core
// Scrolling scope trace with a shadow of the screen; emits only changed pixels.
// ----------------------------------------------------------------------------
// Takes one beat per cycle unless clearing or held by output back-pressure.
// A push scales the current to a height and writes it into a ring buffer (no
// shifting; a head pointer moves). A refresh reads the trace and shadow RAMs
// and, if they differ, emits an erase beat and a draw beat; the draw beat
// waits in a pending slot and a later changing refresh stalls until the pair
// drains. The erase beat is registered as the refresh retires from stage 2.
// After reset both RAMs are cleared one entry per cycle; in_tready stays low
// until all are cleared. Config writes are accepted at any time.
module scrolling_trace_redraw_core
  import str_pkg::*;
#(
  parameter int COLUMNS = 250
) (
  input  logic        clk,
  input  logic        rst_n,
  // config: bit 0 ac_mode
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata,
  // in_tdata: [15:0] sample_amps, [23:16] column
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        in_tuser,   // operation
  // out_tdata: [8:0] pixel_x, [15:9] pixel_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tuser,  // draw_trace
  output logic        out_tlast   // last
);

  localparam int CW = $clog2(COLUMNS);
  localparam int XW = ((CW > 8) ? CW : 8) + 1;

  typedef struct packed {
    logic          v;
    logic          push;
    logic          rfr;
    logic [15:0]   amps;
    logic [CW-1:0] taddr;
    logic [CW-1:0] saddr;
    logic [7:0]    col;
  } s1_t;

  typedef struct packed {
    logic          v;
    logic          rfr;
    logic [CW-1:0] saddr;
    logic [7:0]    col;
  } s2_t;

  logic          ac_mode_r;
  logic          clr_r, clr_nxt;
  logic [CW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [CW-1:0] head_r, head_nxt;
  s1_t           s1_r, s1_nxt;
  s2_t           s2_r, s2_nxt;
  logic          fwd_v_r, fwd_v_nxt;
  logic [HW-1:0] fwd_d_r, fwd_d_nxt;

  logic          out_v_r, out_v_nxt;
  logic [8:0]    out_x_r, out_x_nxt;
  logic [HW-1:0] out_y_r, out_y_nxt;
  logic          out_draw_r, out_draw_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [HW-1:0] pend_y_r, pend_y_nxt;

  logic [XW-1:0] col_x;
  logic          in_rng;
  logic [CW:0]   phys_sum;
  logic [CW-1:0] phys;
  logic          in_acc;
  logic          adv;
  logic          room;

  logic signed [16:0] a_ext, q4, q2, h_raw;
  logic [HW-1:0]      height;

  logic [HW-1:0] trace_rd, shadow_rd, now_h, was_h;
  logic          s2_emit;

  logic          t_we, t_re, s_we, s_re;
  logic [CW-1:0] t_waddr, s_waddr;
  logic [HW-1:0] t_wdata, s_wdata;

  // ---------------- address generation at accept ----------------
  always_comb begin
    col_x    = XW'(in_tdata[23:16]);
    in_rng   = col_x < XW'(COLUMNS);
    phys_sum = (CW+1)'(head_r) + (CW+1)'(col_x[CW-1:0]);
    if (phys_sum >= (CW+1)'(COLUMNS)) begin
      phys = CW'(phys_sum - (CW+1)'(COLUMNS));
    end else begin
      phys = phys_sum[CW-1:0];
    end
  end

  // ---------------- height scaling (stage 1) ----------------
  always_comb begin
    a_ext = {s1_r.amps[15], s1_r.amps};
    // truncate toward zero: bias negatives before the arithmetic shift
    q4 = (a_ext + (a_ext[16] ? 17'sd3 : 17'sd0)) >>> 2;
    q2 = (a_ext + (a_ext[16] ? 17'sd1 : 17'sd0)) >>> 1;
    h_raw = ac_mode_r ? (q4 + MID_HEIGHT) : q2;
    if (h_raw < 17'sd0) begin
      height = '0;
    end else if (h_raw > MAX_HEIGHT) begin
      height = HW'(MAX_HEIGHT);
    end else begin
      height = h_raw[HW-1:0];
    end
  end

  // ---------------- stage 2 compare and retire ----------------
  always_comb begin
    now_h   = trace_rd;
    was_h   = fwd_v_r ? fwd_d_r : shadow_rd;
    s2_emit = s2_r.v && s2_r.rfr && (now_h != was_h);
    room    = !out_v_r || (out_tready && !pend_v_r);
    adv     = !s2_emit || room;
    in_tready = !clr_r && adv;
    in_acc    = in_tvalid && in_tready;
  end

  // ---------------- memories ----------------
  always_comb begin
    t_we    = clr_r || (adv && s1_r.v && s1_r.push);
    t_waddr = clr_r ? clr_cnt_r : s1_r.taddr;
    t_wdata = clr_r ? '0 : height;
    t_re    = adv && s1_r.v && s1_r.rfr;
    s_we    = clr_r || (adv && s2_emit);
    s_waddr = clr_r ? clr_cnt_r : s2_r.saddr;
    s_wdata = clr_r ? '0 : now_h;
    s_re    = adv && s1_r.v && s1_r.rfr;
  end

  str_ram #(.WIDTH(HW), .DEPTH(COLUMNS)) u_trace_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .re    (t_re),
    .raddr (s1_r.taddr),
    .rdata (trace_rd)
  );

  str_ram #(.WIDTH(HW), .DEPTH(COLUMNS)) u_shadow_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s1_r.saddr),
    .rdata (shadow_rd)
  );

  // ---------------- next state ----------------
  always_comb begin
    clr_nxt     = clr_r;
    clr_cnt_nxt = clr_cnt_r;
    head_nxt    = head_r;
    s1_nxt      = s1_r;
    s2_nxt      = s2_r;
    fwd_v_nxt   = fwd_v_r;
    fwd_d_nxt   = fwd_d_r;

    if (clr_r) begin
      if (clr_cnt_r == CW'(COLUMNS - 1)) begin
        clr_nxt = 1'b0;
      end
      clr_cnt_nxt = clr_cnt_r + 1'b1;
    end

    if (in_acc && (op_t'(in_tuser) == OP_PUSH)) begin
      head_nxt = (head_r == CW'(COLUMNS - 1)) ? '0 : head_r + 1'b1;
    end

    if (adv) begin
      s1_nxt.v     = in_acc;
      s1_nxt.push  = op_t'(in_tuser) == OP_PUSH;
      s1_nxt.rfr   = (op_t'(in_tuser) == OP_REFRESH) && in_rng;
      s1_nxt.amps  = in_tdata[15:0];
      s1_nxt.taddr = (op_t'(in_tuser) == OP_PUSH) ? head_r : phys;
      s1_nxt.saddr = col_x[CW-1:0];
      s1_nxt.col   = in_tdata[23:16];

      s2_nxt.v     = s1_r.v;
      s2_nxt.rfr   = s1_r.rfr;
      s2_nxt.saddr = s1_r.saddr;
      s2_nxt.col   = s1_r.col;

      // shadow written this cycle at the column being read: bypass old data
      fwd_v_nxt = s1_r.v && s1_r.rfr && s2_emit && (s1_r.saddr == s2_r.saddr);
      fwd_d_nxt = now_h;
    end
  end

  // ---------------- output buffer ----------------
  always_comb begin
    out_v_nxt    = out_v_r;
    out_x_nxt    = out_x_r;
    out_y_nxt    = out_y_r;
    out_draw_nxt = out_draw_r;
    pend_v_nxt   = pend_v_r;
    pend_y_nxt   = pend_y_r;

    if (out_v_r && out_tready) begin
      if (pend_v_r) begin
        out_y_nxt    = pend_y_r;
        out_draw_nxt = 1'b1;
        pend_v_nxt   = 1'b0;
      end else begin
        out_v_nxt = 1'b0;
      end
    end

    if (adv && s2_emit) begin
      out_v_nxt    = 1'b1;
      out_x_nxt    = 9'(s2_r.col) + LEFT_ORIGIN;
      out_y_nxt    = BASE_Y - was_h;
      out_draw_nxt = 1'b0;
      pend_v_nxt   = 1'b1;
      pend_y_nxt   = BASE_Y - now_h;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac_mode_r <= 1'b0;
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      head_r    <= '0;
      s1_r      <= '0;
      s2_r      <= '0;
      fwd_v_r   <= 1'b0;
      out_v_r   <= 1'b0;
      pend_v_r  <= 1'b0;
    end else begin
      if (cfg_tvalid && cfg_tready) begin
        ac_mode_r <= cfg_tdata[0];
      end
      clr_r     <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      head_r    <= head_nxt;
      s1_r      <= s1_nxt;
      s2_r      <= s2_nxt;
      fwd_v_r   <= fwd_v_nxt;
      out_v_r   <= out_v_nxt;
      pend_v_r  <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_d_r    <= fwd_d_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_draw_r <= out_draw_nxt;
    pend_y_r   <= pend_y_nxt;
  end

  assign cfg_tready = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tuser  = out_draw_r;
  assign out_tlast  = out_draw_r;

`ifndef ASSERT_OFF
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !in_tready)
    else $error("input taken during clearing pass");

  a_pend_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> out_v_r)
    else $error("pending draw beat without erase beat in front");

  a_pair_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_emit) |=> (out_tvalid && !out_tuser && pend_v_r))
    else $error("erase/draw pair not loaded after retire");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= CW'(COLUMNS - 1))
    else $error("ring head out of range");

  a_no_pipe_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> (!s1_r.v && !s2_r.v))
    else $error("pipeline busy during clearing pass");
`endif

endmodule

// File: test/scrolling_trace_redraw_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scrolling_trace_redraw_checker
// Watches the config, sample/refresh and pixel channels of the redraw core,
// keeps its own trace and shadow of the screen, and checks every pixel beat
// against the predicted erase/draw pair in order.
// ----------------------------------------------------------------------------
module scrolling_trace_redraw_checker
  import str_pkg::*;
#(
  parameter int COLUMNS = 250
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_tvalid,
  input  logic        cfg_tready,
  input  logic [7:0]  cfg_tdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned pixels_checked
);

  typedef struct packed {
    logic [8:0] x;
    logic [6:0] y;
    logic       draw;
    logic       last;
  } pixel_t;

  logic [6:0] trace_h [COLUMNS];
  logic [6:0] shown_h [COLUMNS];
  logic       ac_mode;
  pixel_t     expected_pixels [$];

  // amps/4 + 50 (AC) or amps/2 (DC), truncating toward zero, clamped 0..100
  function automatic logic [6:0] scaled_height(input logic signed [15:0] amps,
                                               input logic ac);
    int a;
    int h;
    a = amps;
    h = ac ? (a / 4 + 50) : (a / 2);
    if (h < 0) h = 0;
    if (h > 100) h = 100;
    return h[6:0];
  endfunction

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    int col;
    logic [6:0] now_h;
    logic [6:0] was_h;
    if (!rst_n) begin
      for (int i = 0; i < COLUMNS; i++) begin
        trace_h[i] = '0;
        shown_h[i] = '0;
      end
      ac_mode = 1'b0;
      expected_pixels.delete();
      mismatches = 0;
      pending = 0;
      pixels_checked = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[8:0], out_tdata[15:9], out_tuser, out_tlast};
        pixels_checked++;
        if (expected_pixels.size() == 0) begin
          $display("%0t unexpected pixel beat: expected none, got x=%0d y=%0d draw=%0b last=%0b",
                   $time, got.x, got.y, got.draw, got.last);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.x !== want.x) begin
            $display("%0t pixel_x mismatch: expected %0d, got %0d", $time, want.x, got.x);
            mismatches++;
          end
          if (got.y !== want.y) begin
            $display("%0t pixel_y mismatch: expected %0d, got %0d", $time, want.y, got.y);
            mismatches++;
          end
          if (got.draw !== want.draw) begin
            $display("%0t draw_trace mismatch: expected %0b, got %0b", $time,
                     want.draw, got.draw);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $display("%0t last mismatch: expected %0b, got %0b", $time, want.last, got.last);
            mismatches++;
          end
        end
      end

      if (in_tvalid && in_tready) begin
        if (op_t'(in_tuser) == OP_PUSH) begin
          for (int i = 0; i < COLUMNS - 1; i++) trace_h[i] = trace_h[i + 1];
          trace_h[COLUMNS - 1] = scaled_height(in_tdata[15:0], ac_mode);
        end else begin
          col = in_tdata[23:16];
          if (col < COLUMNS) begin
            now_h = trace_h[col];
            was_h = shown_h[col];
            if (now_h != was_h) begin
              // erase at the old height, then draw at the new one
              want.x = 9'(col) + LEFT_ORIGIN;
              want.y = BASE_Y - was_h;
              want.draw = 1'b0;
              want.last = 1'b0;
              expected_pixels.push_back(want);
              want.y = BASE_Y - now_h;
              want.draw = 1'b1;
              want.last = 1'b1;
              expected_pixels.push_back(want);
              shown_h[col] = now_h;
            end
          end
        end
      end

      if (cfg_tvalid && cfg_tready) ac_mode = cfg_tdata[0];

      pending = expected_pixels.size();
    end
  end

endmodule

// File: test/scrolling_trace_redraw_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scrolling_trace_redraw_core_test
// Drives pushes and column refreshes into the redraw core in both scaling
// modes, with random gaps on both sides and one long output stall; the
// checker instance predicts and compares every pixel beat.
// ----------------------------------------------------------------------------
module scrolling_trace_redraw_core_test;
  import str_pkg::*;

  localparam int COLUMNS = 250;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        cfg_tvalid;
  logic        cfg_tready;
  logic [7:0]  cfg_tdata;    // [0] ac_mode
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;     // [15:0] sample_amps, [23:16] column
  logic        in_tuser;     // operation
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;    // [8:0] pixel_x, [15:9] pixel_y
  logic        out_tuser;    // draw_trace
  logic        out_tlast;    // last

  int unsigned mismatches;
  int unsigned pending;
  int unsigned pixels_checked;
  int unsigned push_count;
  int unsigned refresh_count;
  int unsigned cycles;
  logic        idle_on;

  scrolling_trace_redraw_core #(.COLUMNS(COLUMNS)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  scrolling_trace_redraw_checker #(.COLUMNS(COLUMNS)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_tvalid     (cfg_tvalid),
    .cfg_tready     (cfg_tready),
    .cfg_tdata      (cfg_tdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatches     (mismatches),
    .pending        (pending),
    .pixels_checked (pixels_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("scrolling_trace_redraw_core verification failed");
    $finish;
  end

  // Pixel sink: random stalls per beat, plus one long hold once traffic is flowing
  initial begin
    int unsigned stall;
    int unsigned taken;
    logic held;
    out_tready = 1'b0;
    taken = 0;
    held = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 6) : 0;
      if (!held && taken >= 200) begin
        stall = 300;
        held = 1'b1;
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
      @(negedge clk);
    end
  end

  // starts and ends at a falling edge
  task automatic send_item(input op_t op, input logic [15:0] amps, input logic [7:0] col);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {col, amps};
    do @(posedge clk); while (!in_tready);
    if (op == OP_PUSH) push_count++;
    else refresh_count++;
    @(negedge clk);
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic push(input int amps);
    send_item(OP_PUSH, 16'(amps), 8'($urandom_range(0, 255)));
  endtask

  task automatic refresh(input int col);
    send_item(OP_REFRESH, 16'($urandom_range(0, 65535)), 8'(col));
  endtask

  // only between phases: drain pixels, let trailing pushes settle, then write
  task automatic set_ac_mode(input logic ac);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_tvalid <= 1'b1;
    cfg_tdata <= {7'($urandom_range(0, 127)), ac};
    do @(posedge clk); while (!cfg_tready);
    @(negedge clk);
    cfg_tvalid <= 1'b0;
  endtask

  task automatic random_item();
    int col;
    if ($urandom_range(0, 9) < 6) begin
      case ($urandom_range(0, 9))
        0:       col = $urandom_range(COLUMNS, 255);
        1, 2, 3: col = $urandom_range(0, COLUMNS - 1);
        default: col = $urandom_range(COLUMNS - 60, COLUMNS - 1);
      endcase
      refresh(col);
    end else if ($urandom_range(0, 9) < 4) begin
      push($urandom_range(0, 65535));
    end else begin
      push(int'($urandom_range(0, 1000)) - 500);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_tvalid = 1'b0;
    cfg_tdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_PUSH;
    idle_on = 1'b1;
    push_count = 0;
    refresh_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // DC scaling out of reset: clamps, truncation, no-change and out-of-range refreshes
    refresh(0);
    refresh(255);
    push(32767);
    push(-32768);
    push(200);
    push(201);
    push(-1);
    push(3);
    refresh(COLUMNS - 1);
    refresh(COLUMNS - 1);
    refresh(COLUMNS - 2);
    refresh(COLUMNS - 3);
    refresh(COLUMNS);
    refresh(COLUMNS - 6);

    // AC scaling around mid height
    set_ac_mode(1'b1);
    push(-32768);
    push(32767);
    push(-203);
    push(-199);
    push(203);
    push(199);
    push(0);
    for (int c = COLUMNS - 1; c >= COLUMNS - 8; c--) refresh(c);
    refresh(0);
    refresh(255);

    for (int phase = 0; phase < 4; phase++) begin
      set_ac_mode(phase[0]);
      for (int i = 0; i < 275; i++) begin
        idle_on = ((i / 90) % 3) != 2;
        random_item();
      end
    end
    in_tvalid <= 1'b0;
    idle_on = 1'b1;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("ran %0d pushes and %0d refreshes in DC and AC scaling, %0d pixel beats compared",
             push_count, refresh_count, pixels_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("scrolling_trace_redraw_core verification clean");
    end else begin
      $display("scrolling_trace_redraw_core verification failed");
    end
    $finish;
  end

endmodule
